// ===== src/psn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package psn_pkg;

  localparam int LOSS_DEPTH = 256;
  localparam int IDX_W      = $clog2(LOSS_DEPTH);
  localparam int CNT_W      = $clog2(LOSS_DEPTH + 1);
  localparam int NUM_W      = 32;
  localparam int TIME_W     = 40;
  localparam int IVL_W      = 16;
  localparam int END_WAIT   = 500;
  localparam int IDATA_W    = 32;
  localparam int ODATA_W    = 40;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_CLEAR  = 2'd1,
    KIND_APPEND = 2'd2,
    KIND_NONE   = 2'd3
  } psn_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL    = 1'b0,
    REG_INTERVAL = 1'b1
  } psn_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIN,
    ST_OUT
  } psn_state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic fin;
  } psn_cmd_t;

  typedef struct packed {
    psn_kind_t kind;
  } psn_status_t;

  function automatic logic [IDX_W-1:0] idx_advance(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (i == IDX_W'(LOSS_DEPTH - 1)) r = '0;
    else r = i + IDX_W'(1);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/psn_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module psn_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output psn_pkg::psn_cmd_t         cmd,
  input  wire psn_pkg::psn_status_t status
);
  import psn_pkg::*;

  psn_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        // only ticks and appends produce a result
        if (status.kind == KIND_TICK || status.kind == KIND_APPEND) state_next = ST_FIN;
        else state_next = ST_IDLE;
      end
      ST_FIN: begin
        cmd.fin    = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        m_tvalid = 1'b1;
        if (m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== src/psn_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module psn_dp (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire psn_pkg::psn_cmd_t               cmd,
  output psn_pkg::psn_status_t                 status,
  input  wire logic [1:0]                      in_kind,
  input  wire logic [psn_pkg::NUM_W-1:0]       in_lost,
  input  wire logic                            cfg_we,
  input  wire logic [psn_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [psn_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic                                 res_send,
  output logic [psn_pkg::NUM_W-1:0]            res_number,
  output logic                                 res_retrans,
  output logic                                 res_finished,
  output logic                                 res_overflow
);
  import psn_pkg::*;

  logic [NUM_W-1:0]  loss_mem [LOSS_DEPTH];
  logic [NUM_W-1:0]  rd_data;
  logic [IDX_W-1:0]  head, tail;
  logic [CNT_W-1:0]  count;
  logic [NUM_W-1:0]  next_packet, total_packets;
  logic [IVL_W-1:0]  send_interval;
  logic [TIME_W-1:0] tick_count, due_time;
  psn_kind_t         kind;
  logic [NUM_W-1:0]  lost;
  logic              mem_we;

  assign status.kind = kind;
  assign mem_we = cmd.exec && kind == KIND_APPEND && count < CNT_W'(LOSS_DEPTH);

  // read the queue head every cycle; head is stable between load and exec
  always_ff @(posedge clk) begin
    if (mem_we) loss_mem[tail] <= lost;
    rd_data <= loss_mem[head];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= psn_kind_t'(in_kind);
      lost <= in_lost;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_packets <= '0;
      send_interval <= IVL_W'(1);
    end else if (cfg_we) begin
      unique case (psn_reg_t'(cfg_idx))
        REG_TOTAL:    total_packets <= cfg_wdata[NUM_W-1:0];
        REG_INTERVAL: send_interval <= cfg_wdata[IVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      tail        <= '0;
      count       <= '0;
      next_packet <= '0;
      tick_count  <= '0;
      due_time    <= '0;
    end else if (cmd.exec) begin
      unique case (kind)
        KIND_TICK: begin
          if (count != '0) begin
            head  <= idx_advance(head);
            count <= count - CNT_W'(1);
          end else if (due_time <= tick_count && next_packet < total_packets) begin
            next_packet <= next_packet + NUM_W'(1);
            due_time    <= due_time + TIME_W'(send_interval);
          end
          tick_count <= tick_count + TIME_W'(1);
        end
        KIND_CLEAR: begin
          head  <= '0;
          tail  <= '0;
          count <= '0;
        end
        KIND_APPEND: begin
          if (mem_we) begin
            tail  <= idx_advance(tail);
            count <= count + CNT_W'(1);
          end
        end
        KIND_NONE: ;
        default: ;
      endcase
    end
  end

  // result payload: decision in exec, end condition from updated state in fin
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_send     <= 1'b0;
      res_number   <= '0;
      res_retrans  <= 1'b0;
      res_overflow <= 1'b0;
      if (kind == KIND_TICK) begin
        if (count != '0) begin
          res_send    <= 1'b1;
          res_number  <= rd_data;
          res_retrans <= 1'b1;
        end else if (due_time <= tick_count && next_packet < total_packets) begin
          res_send   <= 1'b1;
          res_number <= next_packet;
        end
      end else if (kind == KIND_APPEND) begin
        res_overflow <= !mem_we;
      end
    end
    if (cmd.fin) begin
      res_finished <= (next_packet >= total_packets) && (count == '0) &&
                      ({1'b0, tick_count} >= ({1'b0, due_time} + (TIME_W+1)'(END_WAIT)));
    end
  end
endmodule
`default_nettype wire

// ===== src/paced_sender_nak_scheduler_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Result path: a tick or append request is latched, executed and has its end condition
//   evaluated before its result is offered; clear and unused requests return to idle after execute without a result.
// Flow: the four-state controller handles one request at a time, so a new request is
//   taken only after the last one is through.
// Reset (rst, synchronous, active high): empty loss queue, counters zero,
//   total_packets 0, send_interval 1; queue storage itself is not cleared.
module paced_sender_nak_scheduler_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // request stream
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [psn_pkg::IDATA_W-1:0]         s_tdata,  // [31:0] lost_number
  input  wire logic [1:0]                          s_tuser,  // [1:0] kind
  // result stream
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // [0] send_valid, [32:1] packet_number, [33] is_retransmit,
  // [34] finished, [35] loss_overflow, [39:36] zero
  output logic [psn_pkg::ODATA_W-1:0]              m_tdata,
  // configuration write channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [psn_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [psn_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import psn_pkg::*;

  psn_cmd_t         cmd;
  psn_status_t      status;
  logic             res_send, res_retrans, res_finished, res_overflow;
  logic [NUM_W-1:0] res_number;

  // registers are always writable; writes must come only while the block is idle; the block does not enforce this
  assign cfg_ready = 1'b1;

  psn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  psn_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .in_kind      (s_tuser),
    .in_lost      (s_tdata[NUM_W-1:0]),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_idx      (cfg_index),
    .cfg_wdata    (cfg_data),
    .res_send     (res_send),
    .res_number   (res_number),
    .res_retrans  (res_retrans),
    .res_finished (res_finished),
    .res_overflow (res_overflow)
  );

  // pack the result, first field in the lowest bit
  assign m_tdata = {(ODATA_W-NUM_W-4)'(0), res_overflow, res_finished, res_retrans,
                    res_number, res_send};

  // one request in flight: never take input while a result waits
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while result pending");

  // after acceptance, hold off further requests
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while busy");

  // no send means zero number and no retransmit flag
  a_idle_payload: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[33:1] == '0))
    else $error("nonzero payload without send");

  // a dropped loss entry comes from an append, which never sends
  a_overflow_no_send: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[35]) |-> !m_tdata[0])
    else $error("overflow flagged on a send");

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import psn_pkg::*;

  // No request, result or register write for this many cycles ends the run.
  // The longest correct quiet spell is a sender gap, a receiver stall, the
  // request latency and the settle time after a drain, far below this.
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 8;

  // m_tdata layout, lowest bit last
  typedef struct packed {
    logic [3:0]       pad;
    logic             overflow;
    logic             finished;
    logic             retrans;
    logic [NUM_W-1:0] number;
    logic             send;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IDATA_W-1:0]    s_tdata   = '0;
  logic [1:0]            s_tuser   = KIND_TICK;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [ODATA_W-1:0]    m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_TOTAL;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  always #2 clk = ~clk;

  paced_sender_nak_scheduler_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Scheduler mirror: registers, loss ring and pacing counters.
  logic [NUM_W-1:0]  total_pkts = '0;
  logic [IVL_W-1:0]  send_gap   = IVL_W'(1);
  logic [NUM_W-1:0]  loss_ring [LOSS_DEPTH];
  logic [IDX_W-1:0]  ring_head  = '0;
  logic [CNT_W-1:0]  ring_count = '0;
  logic [NUM_W-1:0]  next_pkt   = '0;
  logic [TIME_W-1:0] tick_now   = '0;
  logic [TIME_W-1:0] due_at     = '0;

  sched_result_t pending_decisions [$];
  int            mismatches = 0;
  int            items_sent = 0;
  int            gap_odds   = 4;  // 1 in N requests is preceded by a gap, 0 = none
  int            stall_odds = 5;  // odds 1 in N that a receiver stall starts, 0 = none

  function automatic logic transfer_done();
    return (next_pkt >= total_pkts) && (ring_count == 0) &&
           ({1'b0, tick_now} >= {1'b0, due_at} + (TIME_W+1)'(END_WAIT));
  endfunction

  // Apply one accepted request to the mirror and queue the decision it yields.
  function automatic void schedule_item(psn_kind_t k, logic [NUM_W-1:0] lost);
    sched_result_t r;
    int            slot;
    r = '0;
    case (k)
      KIND_TICK: begin
        if (ring_count != 0) begin
          r.number   = loss_ring[ring_head];
          r.send     = 1'b1;
          r.retrans  = 1'b1;
          ring_head  = idx_advance(ring_head);
          ring_count = ring_count - 1'b1;
        end else if (due_at <= tick_now && next_pkt < total_pkts) begin
          r.number = next_pkt;
          r.send   = 1'b1;
          next_pkt = next_pkt + 1'b1;
          due_at   = due_at + TIME_W'(send_gap);
        end
        tick_now = tick_now + 1'b1;
      end
      KIND_CLEAR: begin
        ring_head  = '0;
        ring_count = '0;
        return;
      end
      KIND_APPEND: begin
        if (ring_count < CNT_W'(LOSS_DEPTH)) begin
          slot = int'(ring_head) + int'(ring_count);
          if (slot >= LOSS_DEPTH) slot = slot - LOSS_DEPTH;
          loss_ring[IDX_W'(slot)] = lost;
          ring_count = ring_count + 1'b1;
        end else begin
          r.overflow = 1'b1;
        end
      end
      default: return;
    endcase
    r.finished = transfer_done();
    pending_decisions.push_back(r);
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%t: %s", $realtime, msg);
  endfunction

  function automatic void check_field(string name, logic [NUM_W-1:0] want,
                                      logic [NUM_W-1:0] got);
    if (got !== want)
      flag_mismatch($sformatf("%s: expected %0h, got %0h", name, want, got));
  endfunction

  // Compare every accepted result with the oldest pending decision.
  always @(posedge clk) begin : result_check
    sched_result_t got;
    sched_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_decisions.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %h", m_tdata));
      end else begin
        want = pending_decisions.pop_front();
        check_field("send_valid", want.send, got.send);
        check_field("packet_number", want.number, got.number);
        check_field("is_retransmit", want.retrans, got.retrans);
        check_field("finished", want.finished, got.finished);
        check_field("loss_overflow", want.overflow, got.overflow);
        check_field("padding", want.pad, got.pad);
      end
    end
  end

  // Receiver back-pressure: random stalls of m_tready.
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 10);
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("paced_sender_nak_scheduler_core verification failed");
    $finish;
  end

  // Offer one request, optionally after a gap, and hold it until accepted.
  task automatic send_req(psn_kind_t k, logic [NUM_W-1:0] d);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    schedule_item(k, d);
    items_sent++;
  endtask

  // Hold the sender until every decision is back, then let a clear finish.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Drop valid for one cycle after each write so back-to-back writes stay clean.
  task automatic write_reg(psn_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TOTAL:    total_pkts = val;
      REG_INTERVAL: send_gap   = val[IVL_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [NUM_W-1:0] pick_number();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return NUM_W'($urandom_range(0, 63));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_ticks(int n);
    repeat (n) send_req(KIND_TICK, $urandom);
  endtask

  // Reset defaults, every request kind, field extremes, report replacement.
  task automatic test_directed();
    send_ticks(2);
    drain();
    write_reg(REG_TOTAL, 32'd4);
    write_reg(REG_INTERVAL, 32'd0);
    send_req(KIND_TICK, '1);
    send_req(KIND_NONE, '1);
    send_req(KIND_APPEND, '0);
    send_req(KIND_APPEND, '1);
    send_req(KIND_APPEND, 32'h5A5A_A5A5);
    send_ticks(2);
    send_req(KIND_CLEAR, '1);
    send_ticks(1);
    send_req(KIND_CLEAR, '0);
    send_req(KIND_APPEND, 32'd1);
    send_req(KIND_APPEND, 32'd2);
    send_ticks(4);
    send_req(KIND_NONE, '0);
    send_req(KIND_APPEND, 32'h8000_0000);
    send_req(KIND_CLEAR, 32'h7FFF_FFFF);
    send_ticks(2);
  endtask

  // Fill the ring past its depth, drain most of it, refill across the wrap.
  task automatic test_loss_overflow();
    drain();
    send_req(KIND_CLEAR, $urandom);
    repeat (LOSS_DEPTH + 3) send_req(KIND_APPEND, pick_number());
    send_ticks(LOSS_DEPTH - 6);
    repeat (20) send_req(KIND_APPEND, pick_number());
    send_ticks(30);
  endtask

  // Run out of new packets, wait out the end delay, then revive with a report.
  task automatic test_end_condition();
    int guard;
    drain();
    write_reg(REG_TOTAL, next_pkt + 32'd2);
    write_reg(REG_INTERVAL, 32'd1);
    guard = 0;
    while (!transfer_done() && guard < 700) begin
      send_req(KIND_TICK, $urandom);
      guard++;
    end
    send_ticks(3);
    send_req(KIND_CLEAR, $urandom);
    send_req(KIND_APPEND, pick_number());
    send_req(KIND_APPEND, pick_number());
    send_ticks(4);
  endtask

  // Random phases: mostly ticks and well-formed loss reports, some noise.
  task automatic test_random_traffic();
    int stop_at;
    int pick;
    int odds [4] = '{0, 2, 4, 8};
    repeat (5) begin
      drain();
      gap_odds   = odds[$urandom_range(0, 3)];
      stall_odds = odds[$urandom_range(0, 3)];
      case ($urandom_range(0, 3))
        0: write_reg(REG_TOTAL, 32'd0);
        1: write_reg(REG_TOTAL, '1);
        2: write_reg(REG_TOTAL, $urandom);
        default: write_reg(REG_TOTAL, next_pkt + 32'($urandom_range(0, 40)));
      endcase
      if ($urandom_range(0, 1) == 1)
        write_reg(REG_INTERVAL, 32'($urandom_range(0, 9)));
      stop_at = items_sent + 180;
      while (items_sent < stop_at) begin
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          send_req(KIND_CLEAR, $urandom);
          repeat (($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 8))
            send_req(KIND_APPEND, pick_number());
        end else if (pick < 88) begin
          send_ticks($urandom_range(1, 16));
        end else if (pick < 92) begin
          send_req(KIND_NONE, $urandom);
        end else if (pick < 96) begin
          send_req(KIND_APPEND, pick_number());
        end else if (pick < 98) begin
          send_req(KIND_CLEAR, $urandom);
        end else begin
          drain();
        end
      end
    end
  endtask

  // Register extremes with both sides running flat out.
  task automatic test_extremes();
    drain();
    gap_odds   = 0;
    stall_odds = 0;
    write_reg(REG_TOTAL, '1);
    write_reg(REG_INTERVAL, 32'h0000_FFFF);
    send_ticks(6);
    send_req(KIND_APPEND, '1);
    send_req(KIND_APPEND, '0);
    send_ticks(4);
    send_req(KIND_CLEAR, '0);
    send_ticks(3);
    drain();
    write_reg(REG_TOTAL, 32'd0);
    send_req(KIND_APPEND, $urandom);
    send_ticks(4);
    send_req(KIND_NONE, $urandom);
    send_ticks(2);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_loss_overflow();
    test_end_condition();
    test_random_traffic();
    test_extremes();
    drain();
    if (mismatches == 0 && pending_decisions.size() == 0)
      $display("paced_sender_nak_scheduler_core verification clean");
    else
      $display("paced_sender_nak_scheduler_core verification failed");
    $finish;
  end

endmodule
